[rtl/core/tvts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tvts_pkg;

   // command codes
   localparam logic [2:0] CMD_MOVE     = 3'd0;
   localparam logic [2:0] CMD_HOLD     = 3'd1;
   localparam logic [2:0] CMD_BRAKE    = 3'd2;
   localparam logic [2:0] CMD_FORWARD  = 3'd3;
   localparam logic [2:0] CMD_BACKWARD = 3'd4;

   // register indexes
   localparam logic [2:0] REG_MIDDLE_ONE  = 3'd0;
   localparam logic [2:0] REG_MIDDLE_TWO  = 3'd1;
   localparam logic [2:0] REG_BUBBLE      = 3'd2;
   localparam logic [2:0] REG_DEVIATION   = 3'd3;
   localparam logic [2:0] REG_TRAJ_LENGTH = 3'd4;
   localparam logic [2:0] REG_TIME_LIMIT  = 3'd5;

   // fit coefficients, Q.16
   localparam logic [20:0] K0 = 21'd1126931;
   localparam logic [20:0] K1 = 21'd275907;
   localparam logic [20:0] K2 = 21'd277237;
   localparam logic [20:0] K3 = 21'd126465;
   localparam logic [20:0] K4 = 21'd8965;
   localparam logic [20:0] K5 = 21'd126976;

   localparam logic [31:0] RATIO_LIMIT = 32'd16777216;
   localparam logic [19:0] LEN_MAX     = 20'hFFFFF;

   typedef struct packed {
      logic [19:0]        length_one;
      logic [19:0]        length_two;
      logic signed [15:0] vector_x;
      logic signed [15:0] vector_y;
      logic signed [15:0] vector_z;
   } req_type;

   typedef struct packed {
      logic [10:0] point_index;
      logic        phase;
      logic [2:0]  command_one;
      logic [2:0]  command_two;
      logic [19:0] target_one;
      logic [19:0] target_two;
      logic        ratio_fault;
   } rsp_type;

endpackage
`default_nettype wire

[rtl/core/thrust_vector_trajectory_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// an ended sequence goes straight to the response, a zero x component skips the
// arithmetic, otherwise two bit-serial divisions run, then eight shift-add multiplies of
// one bit per cycle that stop once the multiplier runs out of ones
// throughput: one transaction at a time, the next one is taken the cycle after the result
// is handed off, so a held response stalls the input
// reset: synchronous, restores register defaults and clears position and tick count
module thrust_vector_trajectory_sequencer
   import tvts_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      rsp_type     rsp_data,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [19:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_DIV, ST_MLOAD, ST_MRUN, ST_SUM, ST_ROUND, ST_CMP, ST_DONE
   } state_type;

   localparam int ACC_W = 56;

   state_type state_ff;
   req_type   in_ff;
   rsp_type   rsp_ff, result_ff;
   logic      rsp_valid_ff;

   logic [19:0] mid_one_ff, mid_two_ff;
   logic [15:0] bubble_ff, deviation_ff, time_limit_ff;
   logic [10:0] traj_len_ff;
   logic [10:0] pos_ff;
   logic [15:0] ticks_ff;

   logic        div_sel_ff;
   logic [4:0]  div_cnt_ff;
   logic [15:0] rem_ff;
   logic [31:0] quo_ff;
   logic [24:0] umag_ff, vmag_ff;
   logic        usgn_ff, vsgn_ff;

   logic [2:0]  op_ff;
   logic [57:0] mcand_ff, prod_ff;
   logic [32:0] mplier_ff;
   logic [32:0] uu_ff, vv_ff, uvmag_ff;
   logic        uvsgn_ff;
   logic signed [ACC_W-1:0] base_ff, dsum_ff, s1_ff, s2_ff;
   logic [19:0] t1_ff, t2_ff;
   logic        fault_ff;

   function automatic logic [20:0] absdiff(input logic [19:0] a, input logic [19:0] b);
      return (a > b) ? {1'b0, a - b} : {1'b0, b - a};
   endfunction

   function automatic logic [19:0] to_length(input logic signed [ACC_W-1:0] s);
      logic [ACC_W-1:0] r;
      r = $unsigned(s) + ACC_W'(524288);
      if (s < 0) return 20'd0;
      if (r[ACC_W-1:20] > (ACC_W-20)'(LEN_MAX)) return LEN_MAX;
      return r[39:20];
   endfunction

   function automatic logic [2:0] return_cmd(input logic [19:0] len, input logic [19:0] mid,
                                             input logic [15:0] bub);
      if (absdiff(len, mid) <= {5'd0, bub}) return CMD_BRAKE;
      return (mid > len) ? CMD_FORWARD : CMD_BACKWARD;
   endfunction

   // end of sequence test
   logic [31:0] limit;
   logic        ended;
   always_comb begin
      limit = (32'(traj_len_ff) > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : 32'(traj_len_ff);
      ended = (32'(pos_ff) >= limit) || (ticks_ff >= time_limit_ff);
   end

   // operand magnitudes
   logic [15:0] xmag, ymag, zmag;
   always_comb begin
      xmag = in_ff.vector_x[15] ? 16'(-in_ff.vector_x) : 16'(in_ff.vector_x);
      ymag = in_ff.vector_y[15] ? 16'(-in_ff.vector_y) : 16'(in_ff.vector_y);
      zmag = in_ff.vector_z[15] ? 16'(-in_ff.vector_z) : 16'(in_ff.vector_z);
   end

   // restoring division step, one quotient bit per cycle
   logic [16:0] shifted;
   logic        ge;
   logic [15:0] rem_in;
   logic [31:0] quo_in;
   logic [24:0] qmag;
   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      ge      = shifted >= {1'b0, xmag};
      rem_in  = ge ? 16'(shifted - {1'b0, xmag}) : shifted[15:0];
      quo_in  = {quo_ff[30:0], ge};
      qmag    = (quo_in > RATIO_LIMIT) ? RATIO_LIMIT[24:0] : quo_in[24:0];
   end

   // product as signed accumulator operand
   logic signed [ACC_W-1:0] prod_s;
   assign prod_s = $signed({1'b0, prod_ff[ACC_W-2:0]});

   // end of sequence commands
   logic       far;
   logic [2:0] end_cmd_one, end_cmd_two;
   logic       hold1, hold2;
   always_comb begin
      far = (absdiff(mid_one_ff, in_ff.length_one) > {5'd0, deviation_ff}) ||
            (absdiff(mid_two_ff, in_ff.length_two) > {5'd0, deviation_ff});
      end_cmd_one = far ? return_cmd(in_ff.length_one, mid_one_ff, bubble_ff) : CMD_BRAKE;
      end_cmd_two = far ? return_cmd(in_ff.length_two, mid_two_ff, bubble_ff) : CMD_BRAKE;
      hold1 = absdiff(in_ff.length_one, t1_ff) <= {5'd0, bubble_ff};
      hold2 = absdiff(in_ff.length_two, t2_ff) <= {5'd0, bubble_ff};
   end

   // result moves to the output register once it is free
   logic handoff;
   assign handoff = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         pos_ff        <= '0;
         ticks_ff      <= '0;
         mid_one_ff    <= 20'd69632;
         mid_two_ff    <= 20'd71270;
         bubble_ff     <= 16'd205;
         deviation_ff  <= 16'd410;
         traj_len_ff   <= 11'd1024;
         time_limit_ff <= 16'd500;
      end else begin
         // configuration writes
         if (csr_valid) begin
            case (csr_index)
               REG_MIDDLE_ONE:  mid_one_ff    <= csr_wdata;
               REG_MIDDLE_TWO:  mid_two_ff    <= csr_wdata;
               REG_BUBBLE:      bubble_ff     <= csr_wdata[15:0];
               REG_DEVIATION:   deviation_ff  <= csr_wdata[15:0];
               REG_TRAJ_LENGTH: traj_len_ff   <= csr_wdata[10:0];
               REG_TIME_LIMIT:  time_limit_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (handoff) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  in_ff    <= req_data;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               base_ff    <= $signed(ACC_W'(K0)) <<< 16;
               dsum_ff    <= '0;
               rem_ff     <= '0;
               quo_ff     <= {ymag, 16'd0};
               div_cnt_ff <= '0;
               div_sel_ff <= 1'b0;
               if (ended) begin
                  result_ff <= '{point_index: pos_ff, phase: 1'b1,
                                 command_one: end_cmd_one, command_two: end_cmd_two,
                                 target_one: mid_one_ff, target_two: mid_two_ff,
                                 ratio_fault: 1'b0};
                  state_ff  <= ST_DONE;
               end else if (in_ff.vector_x == '0) begin
                  t1_ff    <= '0;
                  t2_ff    <= '0;
                  fault_ff <= 1'b1;
                  state_ff <= ST_CMP;
               end else begin
                  fault_ff <= 1'b0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_cnt_ff == 5'd31) begin
                  rem_ff     <= '0;
                  div_cnt_ff <= '0;
                  if (!div_sel_ff) begin
                     umag_ff    <= qmag;
                     usgn_ff    <= in_ff.vector_y[15] ^ in_ff.vector_x[15];
                     quo_ff     <= {zmag, 16'd0};
                     div_sel_ff <= 1'b1;
                  end else begin
                     vmag_ff  <= qmag;
                     vsgn_ff  <= in_ff.vector_z[15] ^ in_ff.vector_x[15];
                     op_ff    <= '0;
                     state_ff <= ST_MLOAD;
                  end
               end else begin
                  rem_ff     <= rem_in;
                  quo_ff     <= quo_in;
                  div_cnt_ff <= div_cnt_ff + 5'd1;
               end
            end
            ST_MLOAD: begin
               prod_ff <= '0;
               case (op_ff)
                  3'd0: begin mcand_ff <= 58'(umag_ff); mplier_ff <= 33'(umag_ff); end
                  3'd1: begin mcand_ff <= 58'(umag_ff); mplier_ff <= 33'(vmag_ff); end
                  3'd2: begin mcand_ff <= 58'(vmag_ff); mplier_ff <= 33'(vmag_ff); end
                  3'd3: begin mcand_ff <= 58'(K2);      mplier_ff <= 33'(vmag_ff); end
                  3'd4: begin mcand_ff <= 58'(K3);      mplier_ff <= uu_ff;        end
                  3'd5: begin mcand_ff <= 58'(K5);      mplier_ff <= vv_ff;        end
                  3'd6: begin mcand_ff <= 58'(K1);      mplier_ff <= 33'(umag_ff); end
                  default: begin mcand_ff <= 58'(K4);   mplier_ff <= uvmag_ff;     end
               endcase
               state_ff <= ST_MRUN;
            end
            ST_MRUN: begin
               if (mplier_ff != '0) begin
                  // shift-add, one multiplier bit per cycle
                  if (mplier_ff[0]) prod_ff <= prod_ff + mcand_ff;
                  mcand_ff  <= {mcand_ff[56:0], 1'b0};
                  mplier_ff <= {1'b0, mplier_ff[32:1]};
               end else begin
                  case (op_ff)
                     3'd0: uu_ff <= prod_ff[48:16];
                     3'd1: begin
                        uvmag_ff <= prod_ff[48:16];
                        uvsgn_ff <= usgn_ff ^ vsgn_ff;
                     end
                     3'd2: vv_ff <= prod_ff[48:16];
                     3'd3: base_ff <= vsgn_ff ? base_ff - prod_s : base_ff + prod_s;
                     3'd4: base_ff <= base_ff - prod_s;
                     3'd5: base_ff <= base_ff - prod_s;
                     3'd6: dsum_ff <= usgn_ff ? dsum_ff - prod_s : dsum_ff + prod_s;
                     default: dsum_ff <= uvsgn_ff ? dsum_ff + prod_s : dsum_ff - prod_s;
                  endcase
                  op_ff    <= op_ff + 3'd1;
                  state_ff <= (op_ff == 3'd7) ? ST_SUM : ST_MLOAD;
               end
            end
            ST_SUM: begin
               s1_ff    <= base_ff + dsum_ff;
               s2_ff    <= base_ff - dsum_ff;
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               t1_ff    <= to_length(s1_ff);
               t2_ff    <= to_length(s2_ff);
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               result_ff <= '{point_index: pos_ff, phase: 1'b0,
                              command_one: hold1 ? CMD_HOLD : CMD_MOVE,
                              command_two: hold2 ? CMD_HOLD : CMD_MOVE,
                              target_one: t1_ff, target_two: t2_ff,
                              ratio_fault: fault_ff};
               if (hold1 && hold2) pos_ff <= pos_ff + 11'd1;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               // hand off once the output register is free
               if (handoff) begin
                  rsp_ff   <= result_ff;
                  if (ticks_ff != 16'hFFFF) ticks_ff <= ticks_ff + 16'd1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   // returning phase never issues tracking commands
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.phase |->
         rsp_data.command_one != CMD_MOVE && rsp_data.command_one != CMD_HOLD &&
         rsp_data.command_two != CMD_MOVE && rsp_data.command_two != CMD_HOLD)
      else $error("tracking command during return");

   // a ratio fault zeroes both targets
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ratio_fault |->
         rsp_data.target_one == '0 && rsp_data.target_two == '0 && !rsp_data.phase)
      else $error("fault with nonzero target");

   // position only moves when a tracking result is formed
   assert property (@(posedge clock) disable iff (reset)
      $past(state_ff) != ST_CMP && !$past(reset) |-> $stable(pos_ff))
      else $error("position changed outside compare");
`endif

endmodule
`default_nettype wire
